@@ rtl/core/dwo_pkg.sv @@
// ----------------------------------------------------------------------------
// dwo_pkg
// Shared types and codes for the two-axis readout with work offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package dwo_pkg;

  // Key command codes; the eighth code is unused and acts as no command.
  localparam logic [2:0] FUNC_NONE   = 3'd0;
  localparam logic [2:0] FUNC_NEXT   = 3'd1;
  localparam logic [2:0] FUNC_PREV   = 3'd2;
  localparam logic [2:0] FUNC_ZERO_X = 3'd3;
  localparam logic [2:0] FUNC_ZERO_Y = 3'd4;
  localparam logic [2:0] FUNC_HALF_X = 3'd5;
  localparam logic [2:0] FUNC_HALF_Y = 3'd6;

  // Register indexes (byte address bit 2).
  localparam logic CFG_X_SCALE = 1'b0;
  localparam logic CFG_Y_SCALE = 1'b1;

  // Default scale, mm per count in Q0.32.
  localparam logic [31:0] SCALE_RESET = 32'd46382317;

  localparam int AXES = 2;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] x_count;
    logic signed [31:0] y_count;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] x_mm;
    logic signed [47:0] y_mm;
    logic [2:0]         system_index;
    logic               x_changed;
    logic               y_changed;
  } out_item_t;

  // One queued item: updated offsets and counts per axis, system index and flags.
  typedef struct packed {
    logic [AXES-1:0][31:0] off;
    logic [AXES-1:0][31:0] cnt;
    logic [2:0]            sys;
    logic [AXES-1:0]       chg;
  } work_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/dwo_front.sv @@
// ----------------------------------------------------------------------------
// dwo_front
// Accept items, step the system, update offsets and classify changes.
// ----------------------------------------------------------------------------
`default_nettype none

module dwo_front
  import dwo_pkg::*;
#(
  parameter int NUM_SYSTEMS = 5
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire in_item_t  in_item,
  output logic           in_stall,
  input  wire q_status_t q_status,
  output logic           push,
  output work_t          push_entry
);

  localparam int SYS_W = (NUM_SYSTEMS > 1) ? $clog2(NUM_SYSTEMS) : 1;
  localparam logic [SYS_W-1:0] SYS_LAST = SYS_W'(NUM_SYSTEMS - 1);

  logic [SYS_W-1:0] sys_r, sys_nxt;
  logic             first_r;
  logic [31:0]      last_r   [AXES];
  logic [31:0]      off_r    [AXES][NUM_SYSTEMS];
  logic [31:0]      cnt      [AXES];
  logic [31:0]      off_cur  [AXES];
  logic [31:0]      off_nxt  [AXES];
  logic             moved;
  logic [AXES-1:0]  cmd_hit;
  logic [AXES-1:0]  is_zero;
  logic [AXES-1:0]  is_half;

  // offset -= (offset + count) / 2, truncating toward zero
  function automatic logic [31:0] halve(input logic [31:0] off, input logic [31:0] c);
    logic [31:0] sum;
    logic [31:0] adj;
    sum = off + c;
    adj = sum + 32'(sum[31]);
    return off - {adj[31], adj[31:1]};
  endfunction

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

  assign cnt[AXIS_X] = in_item.x_count;
  assign cnt[AXIS_Y] = in_item.y_count;

  always_comb begin
    sys_nxt = sys_r;
    moved   = 1'b0;
    if (in_item.func == FUNC_NEXT && sys_r != SYS_LAST) begin
      sys_nxt = sys_r + 1'b1;
      moved   = 1'b1;
    end else if (in_item.func == FUNC_PREV && sys_r != '0) begin
      sys_nxt = sys_r - 1'b1;
      moved   = 1'b1;
    end
  end

  always_comb begin
    is_zero = '0;
    is_half = '0;
    unique case (in_item.func)
      FUNC_ZERO_X: is_zero[AXIS_X] = 1'b1;
      FUNC_ZERO_Y: is_zero[AXIS_Y] = 1'b1;
      FUNC_HALF_X: is_half[AXIS_X] = 1'b1;
      FUNC_HALF_Y: is_half[AXIS_Y] = 1'b1;
      default: ;
    endcase
    cmd_hit = is_zero | is_half;
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      off_cur[a] = off_r[a][sys_nxt];
      if (is_zero[a]) begin
        off_nxt[a] = 32'd0 - cnt[a];
      end else if (is_half[a]) begin
        off_nxt[a] = halve(off_cur[a], cnt[a]);
      end else begin
        off_nxt[a] = off_cur[a];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      push_entry.off[a] = off_nxt[a];
      push_entry.cnt[a] = cnt[a];
      push_entry.chg[a] = first_r || moved || (cnt[a] != last_r[a]) || cmd_hit[a];
    end
    push_entry.sys = 3'(sys_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r   <= '0;
      first_r <= 1'b1;
      for (int a = 0; a < AXES; a++) begin
        last_r[a] <= '0;
        for (int i = 0; i < NUM_SYSTEMS; i++) begin
          off_r[a][i] <= '0;
        end
      end
    end else if (push) begin
      sys_r   <= sys_nxt;
      first_r <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        last_r[a]         <= cnt[a];
        off_r[a][sys_nxt] <= off_nxt[a];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dwo_queue.sv @@
// ----------------------------------------------------------------------------
// dwo_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dwo_queue
  import dwo_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t push_entry,
  input  wire logic  pop,
  output work_t      head,
  output q_status_t  status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  work_t            entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign head         = entries_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_FULL);
  assign status.valid = (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dwo_back.sv @@
// ----------------------------------------------------------------------------
// dwo_back
// Convert queued offset and count pairs to millimetres, four stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module dwo_back
  import dwo_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire q_status_t             q_status,
  input  wire work_t                 head,
  output logic                       pop,
  input  wire logic [AXES-1:0][31:0] scale,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item
);

  typedef struct packed {
    logic [2:0]      sys;
    logic [AXES-1:0] chg;
  } meta_t;

  logic                  adv;
  logic                  v1_r, v2_r, v3_r, out_valid_r;
  meta_t                 m1_r, m2_r, m3_r;
  logic [AXES-1:0][31:0] sum_r;
  logic [AXES-1:0][31:0] mag_r;
  logic [AXES-1:0]       neg2_r, neg3_r;
  logic [AXES-1:0][63:0] prod_r;
  logic [AXES-1:0][47:0] mm_r;
  meta_t                 mo_r;

  // Advance the whole pipe whenever the output slot is free or being taken.
  assign adv       = !out_valid_r || !out_stall;
  assign pop       = q_status.valid && adv;
  assign out_valid = out_valid_r;

  always_comb begin
    out_item.x_mm         = mm_r[AXIS_X];
    out_item.y_mm         = mm_r[AXIS_Y];
    out_item.system_index = mo_r.sys;
    out_item.x_changed    = mo_r.chg[AXIS_X];
    out_item.y_changed    = mo_r.chg[AXIS_Y];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= '{sys: head.sys, chg: head.chg};
      m2_r <= m1_r;
      m3_r <= m2_r;
      mo_r <= m3_r;
      for (int a = 0; a < AXES; a++) begin
        sum_r[a]  <= head.off[a] + head.cnt[a];
        neg2_r[a] <= sum_r[a][31];
        mag_r[a]  <= sum_r[a][31] ? (32'd0 - sum_r[a]) : sum_r[a];
        neg3_r[a] <= neg2_r[a];
        prod_r[a] <= 64'(mag_r[a]) * 64'(scale[a]);
        mm_r[a]   <= neg3_r[a] ? (48'd0 - prod_r[a][63:16]) : prod_r[a][63:16];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dro_work_offset_engine_unit.sv @@
// ----------------------------------------------------------------------------
// dro_work_offset_engine_unit
// Two-axis digital readout with selectable work coordinate systems. Each item
// brings both encoder counts and one key command (next or previous system,
// zero or halve one axis) and yields one result item: both positions of the
// selected system in signed Q32.16 millimetres, the system index and a
// changed flag per axis. The block takes one item per clock cycle unless the
// queue is full; that rate is set by the front, which reads, updates and
// writes back one offset pair of the selected system as it accepts an item.
// The back runs the conversion in four registered stages (sum, magnitude,
// 32x32 multiply, scale and sign), which an item enters from the queue.
// A QUEUE_DEPTH-entry queue between front and back keeps accepting items
// while results wait at the output, until it is full. Scales are written
// over the APB port at byte address 0 (x) and 4 (y) and read back at the
// same addresses; write them only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module dro_work_offset_engine_unit
  import dwo_pkg::*;
#(
  parameter int NUM_SYSTEMS = 5,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // item input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [AXES-1:0][31:0] scale_r;
  logic                  cfg_wr;
  logic                  push, pop;
  work_t                 push_entry, head;
  q_status_t             q_status;

  // Config: zero-wait APB, register index in address bit 2.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      CFG_X_SCALE: cfg_prdata = scale_r[AXIS_X];
      CFG_Y_SCALE: cfg_prdata = scale_r[AXIS_Y];
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r[AXIS_X] <= SCALE_RESET;
      scale_r[AXIS_Y] <= SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_X_SCALE: scale_r[AXIS_X] <= cfg_pwdata;
        CFG_Y_SCALE: scale_r[AXIS_Y] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Front: step the system, update the offset pair, flag changes.
  dwo_front #(
    .NUM_SYSTEMS(NUM_SYSTEMS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .q_status  (q_status),
    .push      (push),
    .push_entry(push_entry)
  );

  // Queue: decouple the front from output stalls.
  dwo_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Back: convert to millimetres and hold the result for the consumer.
  dwo_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .scale    (scale_r),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

@@ rtl/core/dwo_checker.sv @@
// ----------------------------------------------------------------------------
// dwo_checker
// Port-level checks for the readout unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dwo_checker
  import dwo_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire out_item_t   out_item,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata,
  input wire logic        cfg_pready
);

  logic       out_acc;
  logic       cfg_wr;
  logic       have_last_r;
  logic [2:0] last_sys_r;

  assign out_acc = out_valid && !out_stall;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      last_sys_r  <= '0;
    end else if (out_acc) begin
      have_last_r <= 1'b1;
      last_sys_r  <= out_item.system_index;
    end
  end

  // A held result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result does not change.
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result changed while stalled");

  // A system switch between delivered results flags both axes.
  a_sys_switch_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && have_last_r && (out_item.system_index != last_sys_r)
      |-> out_item.x_changed && out_item.y_changed)
    else $error("system switch without both changed flags");

  // A written scale reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_wr |=>
      (cfg_paddr[2] != $past(cfg_paddr[2])) || (cfg_prdata == $past(cfg_pwdata)))
    else $error("scale readback mismatch");

endmodule

bind dro_work_offset_engine_unit dwo_checker u_dwo_checker (.*);

`default_nettype wire

@@ bench/dro_work_offset_engine_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dro_work_offset_engine_unit_tb
// Self-checking bench for the two-axis readout with work offsets. A directed
// table walks the command set and the corner cases, then random phases run
// under different scale settings. Every accepted item goes through a local
// model of the offsets, system selection and Q32.16 conversion; each result
// item is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------

module dro_work_offset_engine_unit_tb;
  import dwo_pkg::*;

  localparam int NUM_SYS         = 5;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 8;   // back end is four stages deep
  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam logic [2:0] ADDR_X = {CFG_X_SCALE, 2'b00};
  localparam logic [2:0] ADDR_Y = {CFG_Y_SCALE, 2'b00};

  // Bench-side signals; the driven ones are known from time zero.
  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_item_t    in_item     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_item_t   out_item;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Run bookkeeping.
  int  mismatches       = 0;
  int  items_sent       = 0;
  int  readings_checked = 0;
  int  settings_done    = 0;
  bit  calm             = 1'b0;  // set for the last phase: no idling on either side

  // Expected result items, oldest first.
  out_item_t expected_readings[$];

  // Local model state: offsets per system, selection, last counts, scales.
  logic [31:0] wo_x_off [NUM_SYS] = '{default: '0};
  logic [31:0] wo_y_off [NUM_SYS] = '{default: '0};
  int          wo_sys      = 0;
  logic [31:0] seen_x      = '0;
  logic [31:0] seen_y      = '0;
  bit          fresh_start = 1'b1;
  logic [31:0] x_scale_r   = SCALE_RESET;
  logic [31:0] y_scale_r   = SCALE_RESET;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct {
    logic [2:0]  func;
    logic [31:0] x;
    logic [31:0] y;
    bit          typed;
    out_item_t   want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  dro_work_offset_engine_unit #(
    .NUM_SYSTEMS(NUM_SYS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("dro_work_offset_engine_unit_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Signed 32-bit sum times unsigned Q0.32 scale, shifted down by 16 with
  // truncation toward zero: work on the magnitude, then restore the sign.
  function automatic logic [47:0] counts_to_mm(logic [31:0] off, logic [31:0] cnt,
                                               logic [31:0] scale);
    logic [31:0] sum;
    logic [31:0] mag;
    logic [63:0] prod;
    logic [47:0] q;
    sum  = off + cnt;
    mag  = sum[31] ? (~sum + 32'd1) : sum;
    prod = {32'd0, mag} * {32'd0, scale};
    q    = prod[63:16];
    return sum[31] ? (48'd0 - q) : q;
  endfunction

  // offset -= (offset + count) / 2, sum wraps, division truncates toward zero
  function automatic logic [31:0] halve_offset(logic [31:0] off, logic [31:0] cnt);
    logic signed [31:0] sum;
    logic signed [31:0] q;
    sum = off + cnt;
    q   = sum / 2;
    return off - q;
  endfunction

  // Advance the model by one item and return the result it should produce.
  function automatic out_item_t predict_reading(in_item_t it);
    logic      xch;
    logic      ych;
    out_item_t r;
    xch = fresh_start;
    ych = fresh_start;
    fresh_start = 1'b0;
    // system step first; no wrap at either end
    if (it.func == FUNC_NEXT && wo_sys + 1 < NUM_SYS) begin
      wo_sys++;
      xch = 1'b1;
      ych = 1'b1;
    end else if (it.func == FUNC_PREV && wo_sys != 0) begin
      wo_sys--;
      xch = 1'b1;
      ych = 1'b1;
    end
    if (it.x_count != seen_x) begin
      seen_x = it.x_count;
      xch = 1'b1;
    end
    if (it.y_count != seen_y) begin
      seen_y = it.y_count;
      ych = 1'b1;
    end
    // zero / half act on the newly selected system
    case (it.func)
      FUNC_ZERO_X: begin
        wo_x_off[wo_sys] = 32'd0 - it.x_count;
        xch = 1'b1;
      end
      FUNC_ZERO_Y: begin
        wo_y_off[wo_sys] = 32'd0 - it.y_count;
        ych = 1'b1;
      end
      FUNC_HALF_X: begin
        wo_x_off[wo_sys] = halve_offset(wo_x_off[wo_sys], it.x_count);
        xch = 1'b1;
      end
      FUNC_HALF_Y: begin
        wo_y_off[wo_sys] = halve_offset(wo_y_off[wo_sys], it.y_count);
        ych = 1'b1;
      end
      default: ;
    endcase
    r.x_mm         = counts_to_mm(wo_x_off[wo_sys], it.x_count, x_scale_r);
    r.y_mm         = counts_to_mm(wo_y_off[wo_sys], it.y_count, y_scale_r);
    r.system_index = wo_sys[2:0];
    r.x_changed    = xch;
    r.y_changed    = ych;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] func, logic [31:0] x, logic [31:0] y,
                                  bit typed, logic [47:0] xmm, logic [47:0] ymm,
                                  logic [2:0] sys, logic xch, logic ych);
    dir_row_t row;
    row.func  = func;
    row.x     = x;
    row.y     = y;
    row.typed = typed;
    row.want  = '{x_mm: xmm, y_mm: ymm, system_index: sys,
                  x_changed: xch, y_changed: ych};
    dir_rows.push_back(row);
  endfunction

  // Mostly small moves around the last count, some repeats, some wild values.
  function automatic logic [31:0] pick_count(logic [31:0] prev);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3, 4:    return prev;
      default: return prev + $urandom_range(0, 400) - 32'd200;
    endcase
  endfunction

  // Present one item, hold it until accepted, then record its expected result.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = predict_reading(it);
    expected_readings.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic wait_for_readings();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup, access until pready, then back to idle.
  task automatic apb_access(input bit wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write both scales, mirror them in the model, and read them back.
  task automatic set_scales(input logic [31:0] xs, input logic [31:0] ys);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_X, xs, rd);
    x_scale_r = xs;
    apb_access(1'b1, ADDR_Y, ys, rd);
    y_scale_r = ys;
    apb_access(1'b0, ADDR_X, '0, rd);
    if (rd !== xs) report_mismatch("x_scale readback", 64'(rd), 64'(xs));
    apb_access(1'b0, ADDR_Y, '0, rd);
    if (rd !== ys) report_mismatch("y_scale readback", 64'(rd), 64'(ys));
    settings_done++;
  endtask

  // Result side: stall in random bursts, none once the run goes calm.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result item against the oldest prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("result item with nothing expected", 64'(out_item.x_mm), '0);
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (out_item.x_mm !== want.x_mm)
          report_mismatch("x_mm", 64'(out_item.x_mm), 64'(want.x_mm));
        if (out_item.y_mm !== want.y_mm)
          report_mismatch("y_mm", 64'(out_item.y_mm), 64'(want.y_mm));
        if (out_item.system_index !== want.system_index)
          report_mismatch("system_index", 64'(out_item.system_index),
                          64'(want.system_index));
        if (out_item.x_changed !== want.x_changed)
          report_mismatch("x_changed", 64'(out_item.x_changed), 64'(want.x_changed));
        if (out_item.y_changed !== want.y_changed)
          report_mismatch("y_changed", 64'(out_item.y_changed), 64'(want.y_changed));
      end
    end
  end

  initial begin : stimulus
    in_item_t    it;
    logic [31:0] xs;
    logic [31:0] ys;

    // Directed table. Typed rows are read straight off the default scale:
    // one count is 707 in Q32.16.
    // first item after reset flags both axes
    add_row(FUNC_NONE,   32'd0, 32'd0, 1'b1, 48'd0, 48'd0, 3'd0, 1'b1, 1'b1);
    // nothing moved, nothing flagged
    add_row(FUNC_NONE,   32'd0, 32'd0, 1'b1, 48'd0, 48'd0, 3'd0, 1'b0, 1'b0);
    // previous at system zero does nothing
    add_row(FUNC_PREV,   32'd0, 32'd0, 1'b1, 48'd0, 48'd0, 3'd0, 1'b0, 1'b0);
    add_row(FUNC_NONE,   32'd1, 32'd0, 1'b1, 48'd707, 48'd0, 3'd0, 1'b1, 1'b0);
    add_row(FUNC_NONE,   32'hFFFF_FFFF, 32'd0, 1'b1, -48'sd707, 48'd0, 3'd0, 1'b1, 1'b0);
    // zeroing flags the axis even with the count unchanged
    add_row(FUNC_ZERO_X, 32'hFFFF_FFFF, 32'd0, 1'b1, 48'd0, 48'd0, 3'd0, 1'b1, 1'b0);
    // sum wraps past the top, then zero of the most negative count wraps
    add_row(FUNC_NONE,   32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_ZERO_Y, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // halving from the most negative sum, then an odd positive sum
    add_row(FUNC_HALF_X, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_HALF_Y, 32'h7FFF_FFFF, 32'hFFFF_FFF9, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // walk to the last system, then next at the top does nothing
    add_row(FUNC_NEXT,   32'h7FFF_FFFF, 32'hFFFF_FFF9, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_NEXT,   32'd100,       32'hFFFF_FFF9, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_NEXT,   32'd100,       32'd250,       1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_NEXT,   32'd100,       32'd250,       1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_NEXT,   32'd100,       32'd250,       1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_ZERO_X, 32'd5,         32'd250,       1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_HALF_Y, 32'd5,         32'hFFFF_FFFD, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_HALF_X, 32'd12345,     32'hFFFF_FFFD, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // unused code seven acts as no command
    add_row(FUNC_UNUSED, 32'd12345,     32'hFFFF_FFFD, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_PREV,   32'd12345,     32'hFFFF_FFFD, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_ZERO_Y, 32'd12345,     32'h7FFF_FFFF, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    // back down to system zero: its offsets must still be there
    add_row(FUNC_PREV,   32'd12345,     32'h7FFF_FFFF, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_PREV,   32'd12345,     32'h7FFF_FFFF, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_PREV,   32'd0,         32'd0,         1'b0, '0, '0, '0, 1'b0, 1'b0);
    add_row(FUNC_NONE,   32'd0,         32'd0,         1'b0, '0, '0, '0, 1'b0, 1'b0);

    // Synchronous reset, applied once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.func    = dir_rows[i].func;
      it.x_count = dir_rows[i].x;
      it.y_count = dir_rows[i].y;
      send_item(it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under its own scale setting; the block is drained
    // before every register write, which also gives the full sender pause.
    for (int p = 0; p < PHASES; p++) begin
      wait_for_readings();
      case (p)
        0:       begin xs = 32'h0000_0000; ys = 32'hFFFF_FFFF; end
        1:       begin xs = 32'hFFFF_FFFF; ys = 32'h0000_0000; end
        2:       begin xs = 32'h0000_0001; ys = 32'h8000_0000; end
        5:       begin xs = 32'hFFFF_FFFF; ys = 32'hFFFF_FFFF; end
        7:       begin xs = SCALE_RESET;   ys = $urandom;      end
        default: begin xs = $urandom;      ys = $urandom;      end
      endcase
      set_scales(xs, ys);
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // about four in ten items carry no command; the rest spread over all
        // other codes, the unused one included
        if ($urandom_range(0, 9) < 4) it.func = FUNC_NONE;
        else                          it.func = 3'($urandom_range(1, 7));
        it.x_count = pick_count(seen_x);
        it.y_count = pick_count(seen_y);
        send_item(it, 1'b0, '0);
      end
    end

    wait_for_readings();
    $display("covered %0d items (all commands, both system ends, wrap and halving cases)",
             items_sent);
    $display("checked %0d result items over %0d scale settings", readings_checked,
             settings_done);
    if (mismatches == 0) begin
      $display("dro_work_offset_engine_unit_tb: done, clean");
    end else begin
      $display("dro_work_offset_engine_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
